@@ rtl/core/aes128_pkg.sv @@
// ----------------------------------------------------------------------------
// AES-128 shared definitions
// S-box, round constants, round helpers and register indexes.
// ----------------------------------------------------------------------------
package aes128_pkg;

  localparam int NumRounds = 10;

  typedef logic [127:0] blk_t;

  typedef enum logic {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } cfg_idx_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7C; 8'h02: r=8'h77; 8'h03: r=8'h7B;
      8'h04: r=8'hF2; 8'h05: r=8'h6B; 8'h06: r=8'h6F; 8'h07: r=8'hC5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0A: r=8'h67; 8'h0B: r=8'h2B;
      8'h0C: r=8'hFE; 8'h0D: r=8'hD7; 8'h0E: r=8'hAB; 8'h0F: r=8'h76;
      8'h10: r=8'hCA; 8'h11: r=8'h82; 8'h12: r=8'hC9; 8'h13: r=8'h7D;
      8'h14: r=8'hFA; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hF0;
      8'h18: r=8'hAD; 8'h19: r=8'hD4; 8'h1A: r=8'hA2; 8'h1B: r=8'hAF;
      8'h1C: r=8'h9C; 8'h1D: r=8'hA4; 8'h1E: r=8'h72; 8'h1F: r=8'hC0;
      8'h20: r=8'hB7; 8'h21: r=8'hFD; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3F; 8'h26: r=8'hF7; 8'h27: r=8'hCC;
      8'h28: r=8'h34; 8'h29: r=8'hA5; 8'h2A: r=8'hE5; 8'h2B: r=8'hF1;
      8'h2C: r=8'h71; 8'h2D: r=8'hD8; 8'h2E: r=8'h31; 8'h2F: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hC7; 8'h32: r=8'h23; 8'h33: r=8'hC3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9A;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3A: r=8'h80; 8'h3B: r=8'hE2;
      8'h3C: r=8'hEB; 8'h3D: r=8'h27; 8'h3E: r=8'hB2; 8'h3F: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2C; 8'h43: r=8'h1A;
      8'h44: r=8'h1B; 8'h45: r=8'h6E; 8'h46: r=8'h5A; 8'h47: r=8'hA0;
      8'h48: r=8'h52; 8'h49: r=8'h3B; 8'h4A: r=8'hD6; 8'h4B: r=8'hB3;
      8'h4C: r=8'h29; 8'h4D: r=8'hE3; 8'h4E: r=8'h2F; 8'h4F: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hD1; 8'h52: r=8'h00; 8'h53: r=8'hED;
      8'h54: r=8'h20; 8'h55: r=8'hFC; 8'h56: r=8'hB1; 8'h57: r=8'h5B;
      8'h58: r=8'h6A; 8'h59: r=8'hCB; 8'h5A: r=8'hBE; 8'h5B: r=8'h39;
      8'h5C: r=8'h4A; 8'h5D: r=8'h4C; 8'h5E: r=8'h58; 8'h5F: r=8'hCF;
      8'h60: r=8'hD0; 8'h61: r=8'hEF; 8'h62: r=8'hAA; 8'h63: r=8'hFB;
      8'h64: r=8'h43; 8'h65: r=8'h4D; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hF9; 8'h6A: r=8'h02; 8'h6B: r=8'h7F;
      8'h6C: r=8'h50; 8'h6D: r=8'h3C; 8'h6E: r=8'h9F; 8'h6F: r=8'hA8;
      8'h70: r=8'h51; 8'h71: r=8'hA3; 8'h72: r=8'h40; 8'h73: r=8'h8F;
      8'h74: r=8'h92; 8'h75: r=8'h9D; 8'h76: r=8'h38; 8'h77: r=8'hF5;
      8'h78: r=8'hBC; 8'h79: r=8'hB6; 8'h7A: r=8'hDA; 8'h7B: r=8'h21;
      8'h7C: r=8'h10; 8'h7D: r=8'hFF; 8'h7E: r=8'hF3; 8'h7F: r=8'hD2;
      8'h80: r=8'hCD; 8'h81: r=8'h0C; 8'h82: r=8'h13; 8'h83: r=8'hEC;
      8'h84: r=8'h5F; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hC4; 8'h89: r=8'hA7; 8'h8A: r=8'h7E; 8'h8B: r=8'h3D;
      8'h8C: r=8'h64; 8'h8D: r=8'h5D; 8'h8E: r=8'h19; 8'h8F: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4F; 8'h93: r=8'hDC;
      8'h94: r=8'h22; 8'h95: r=8'h2A; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hEE; 8'h9A: r=8'hB8; 8'h9B: r=8'h14;
      8'h9C: r=8'hDE; 8'h9D: r=8'h5E; 8'h9E: r=8'h0B; 8'h9F: r=8'hDB;
      8'hA0: r=8'hE0; 8'hA1: r=8'h32; 8'hA2: r=8'h3A; 8'hA3: r=8'h0A;
      8'hA4: r=8'h49; 8'hA5: r=8'h06; 8'hA6: r=8'h24; 8'hA7: r=8'h5C;
      8'hA8: r=8'hC2; 8'hA9: r=8'hD3; 8'hAA: r=8'hAC; 8'hAB: r=8'h62;
      8'hAC: r=8'h91; 8'hAD: r=8'h95; 8'hAE: r=8'hE4; 8'hAF: r=8'h79;
      8'hB0: r=8'hE7; 8'hB1: r=8'hC8; 8'hB2: r=8'h37; 8'hB3: r=8'h6D;
      8'hB4: r=8'h8D; 8'hB5: r=8'hD5; 8'hB6: r=8'h4E; 8'hB7: r=8'hA9;
      8'hB8: r=8'h6C; 8'hB9: r=8'h56; 8'hBA: r=8'hF4; 8'hBB: r=8'hEA;
      8'hBC: r=8'h65; 8'hBD: r=8'h7A; 8'hBE: r=8'hAE; 8'hBF: r=8'h08;
      8'hC0: r=8'hBA; 8'hC1: r=8'h78; 8'hC2: r=8'h25; 8'hC3: r=8'h2E;
      8'hC4: r=8'h1C; 8'hC5: r=8'hA6; 8'hC6: r=8'hB4; 8'hC7: r=8'hC6;
      8'hC8: r=8'hE8; 8'hC9: r=8'hDD; 8'hCA: r=8'h74; 8'hCB: r=8'h1F;
      8'hCC: r=8'h4B; 8'hCD: r=8'hBD; 8'hCE: r=8'h8B; 8'hCF: r=8'h8A;
      8'hD0: r=8'h70; 8'hD1: r=8'h3E; 8'hD2: r=8'hB5; 8'hD3: r=8'h66;
      8'hD4: r=8'h48; 8'hD5: r=8'h03; 8'hD6: r=8'hF6; 8'hD7: r=8'h0E;
      8'hD8: r=8'h61; 8'hD9: r=8'h35; 8'hDA: r=8'h57; 8'hDB: r=8'hB9;
      8'hDC: r=8'h86; 8'hDD: r=8'hC1; 8'hDE: r=8'h1D; 8'hDF: r=8'h9E;
      8'hE0: r=8'hE1; 8'hE1: r=8'hF8; 8'hE2: r=8'h98; 8'hE3: r=8'h11;
      8'hE4: r=8'h69; 8'hE5: r=8'hD9; 8'hE6: r=8'h8E; 8'hE7: r=8'h94;
      8'hE8: r=8'h9B; 8'hE9: r=8'h1E; 8'hEA: r=8'h87; 8'hEB: r=8'hE9;
      8'hEC: r=8'hCE; 8'hED: r=8'h55; 8'hEE: r=8'h28; 8'hEF: r=8'hDF;
      8'hF0: r=8'h8C; 8'hF1: r=8'hA1; 8'hF2: r=8'h89; 8'hF3: r=8'h0D;
      8'hF4: r=8'hBF; 8'hF5: r=8'hE6; 8'hF6: r=8'h42; 8'hF7: r=8'h68;
      8'hF8: r=8'h41; 8'hF9: r=8'h99; 8'hFA: r=8'h2D; 8'hFB: r=8'h0F;
      8'hFC: r=8'hB0; 8'hFD: r=8'h54; 8'hFE: r=8'hBB; 8'hFF: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // round constant for round 1..10
  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] r;
    case (rnd)
      4'd1:  r = 8'h01;
      4'd2:  r = 8'h02;
      4'd3:  r = 8'h04;
      4'd4:  r = 8'h08;
      4'd5:  r = 8'h10;
      4'd6:  r = 8'h20;
      4'd7:  r = 8'h40;
      4'd8:  r = 8'h80;
      4'd9:  r = 8'h1b;
      4'd10: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block sits at bits 127-8i
  function automatic logic [7:0] get_byte(input blk_t b, input int i);
    return b[127 - 8*i -: 8];
  endfunction

  // next round key from the previous one
  function automatic blk_t next_key(input blk_t k, input logic [3:0] rnd);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rcon(rnd), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // SubBytes, ShiftRows, optional MixColumns
  function automatic blk_t round_core(input blk_t s, input logic mix);
    blk_t t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(r + 4*c) -: 8] = sbox(get_byte(s, r + 4*((c + r) % 4)));
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = get_byte(t, 4*c);
        a1 = get_byte(t, 4*c + 1);
        a2 = get_byte(t, 4*c + 2);
        a3 = get_byte(t, 4*c + 3);
        al = a0 ^ a1 ^ a2 ^ a3;
        t[127 - 32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                               a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
      end
    end
    return t;
  endfunction

endpackage

@@ rtl/core/aes128_round.sv @@
// ----------------------------------------------------------------------------
// AES-128 round stage
// One registered cipher round with its inline key schedule step.
// ----------------------------------------------------------------------------
module aes128_round
  import aes128_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [3:0] rnd,      // round number 1..10
  input  logic       vld_in,
  input  blk_t       st_in,
  input  blk_t       key_in,   // previous round key
  output logic       vld_out,
  output blk_t       st_out,
  output blk_t       key_out   // this round's key
);

  blk_t key_nxt;
  blk_t st_nxt;
  logic vld_r;
  blk_t st_r;
  blk_t key_r;

  assign key_nxt = next_key(key_in, rnd);
  assign st_nxt  = round_core(st_in, rnd != 4'(NumRounds)) ^ key_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r  <= st_nxt;
      key_r <= key_nxt;
    end
  end

  assign vld_out = vld_r;
  assign st_out  = st_r;
  assign key_out = key_r;

endmodule

@@ rtl/core/aes128_encrypt_block.sv @@
// ----------------------------------------------------------------------------
// AES-128 encryption pipeline
// Fully unrolled FIPS-197 encryption, one 128-bit block per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   in_tdata  beat: plaintext block, {plain_low, plain_high} (high in 63:0).
//   out_tdata beat: ciphertext block, same packing.
//   cfg_we/cfg_index/cfg_wdata write the key halves; write only when idle.
// Stages: one stage for the initial AddRoundKey plus one stage per round,
//   each stage carrying its round key alongside the state (key expansion
//   is inline).
// Throughput: one block per cycle while not stalled; the whole pipe advances together.
// Stall: when out_tready is low and the last stage holds a result, every
//   stage freezes; in_tready drops only then, so no beat is lost or repeated.
// Reset: clears all stage valid bits and both key registers to zero.
// ----------------------------------------------------------------------------
module aes128_encrypt_block
  import aes128_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] plain_high, [127:64] plain_low
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [63:0] cipher_high, [127:64] cipher_low
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_wdata
);

  logic [63:0] key_high_r;
  logic [63:0] key_low_r;
  logic        en;
  logic        v0_r;
  blk_t        s0_r;
  blk_t        k0_r;

  logic        vld [NumRounds+1];
  blk_t        st  [NumRounds+1];
  blk_t        key [NumRounds+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KEY_HIGH: key_high_r <= cfg_wdata;
        CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipe advances unless the output holds an untaken result
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 0: initial AddRoundKey
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= {in_tdata[63:0], in_tdata[127:64]} ^ {key_high_r, key_low_r};
      k0_r <= {key_high_r, key_low_r};
    end
  end

  assign vld[0] = v0_r;
  assign st[0]  = s0_r;
  assign key[0] = k0_r;

  for (genvar g = 1; g <= NumRounds; g++) begin : g_rnd
    aes128_round u_rnd (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .rnd     (4'(g)),
      .vld_in  (vld[g-1]),
      .st_in   (st[g-1]),
      .key_in  (key[g-1]),
      .vld_out (vld[g]),
      .st_out  (st[g]),
      .key_out (key[g])
    );
  end

  assign out_tvalid = vld[NumRounds];
  assign out_tdata  = {st[NumRounds][63:0], st[NumRounds][127:64]};

`ifndef SYNTH
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |=> v0_r == $past(in_tvalid))
    else $error("stage 0 valid lost");
`endif

endmodule

@@ test/tb_aes128_encrypt_block.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 encryption pipeline testbench
// Drives plaintext beats under several keys. Each result is checked against
// an in-bench AES-128 cipher, itself checked against known answers from the standard.
// Both stream sides idle at random, and one long output hold fills the pipe.
// ----------------------------------------------------------------------------
module tb_aes128_encrypt_block;
  import aes128_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PipeDrain  = 20;     // pipe is 11 deep, plus margin
  localparam int HoldCycles = 200;    // long output back-pressure stretch
  localparam int HoldAt     = 300;    // ... started after this many results
  localparam int RandItems  = 1530;
  localparam int KeyPhases  = 6;

  // one directed row: key, plaintext, and a known answer where one exists
  typedef struct packed {
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [63:0] pt_hi;
    logic [63:0] pt_lo;
    logic        known;
    logic [63:0] ct_hi;
    logic [63:0] ct_lo;
  } vec_row_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // [63:0] plain_high, [127:64] plain_low
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // [63:0] cipher_high, [127:64] cipher_low
  logic         cfg_we;
  logic         cfg_index;
  logic [63:0]  cfg_wdata;

  aes128_encrypt_block dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // cipher model state
  logic [7:0]  sub_byte [256];
  logic [63:0] key_hi_q, key_lo_q;
  cipher_t     cipher_q [$];   // ciphertexts still to come out
  int          err_cnt;
  int          rx_cnt;
  bit          calm;           // no random idling on either side while set

  // directed rows; all-zero key first so reset key is exercised unwritten
  localparam int NumRows = 14;
  vec_row_t rows [NumRows] = '{
    '{64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
    '{64'h0, 64'h0, '1, '1, 1'b0, 64'h0, 64'h0},
    '{64'h0, 64'h0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 64'h0, 64'h0},
    '{64'h0, 64'h0, 64'h8000000000000000, 64'h0, 1'b0, 64'h0, 64'h0},
    '{64'h0, 64'h0, 64'h0, 64'h1, 1'b0, 64'h0, 64'h0},
    '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0011223344556677,
      64'h8899aabbccddeeff, 1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
    '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, 64'h0, 1'b0, 64'h0, 64'h0},
    '{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 64'h3243f6a8885a308d,
      64'h313198a2e0370734, 1'b1, 64'h3925841d02dc09fb, 64'hdc118597196a0b32},
    '{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 64'h0, '1, 1'b0, 64'h0, 64'h0},
    '{'1, '1, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
    '{'1, '1, '1, '1, 1'b0, 64'h0, 64'h0},
    '{'1, 64'h0, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 64'h0, 64'h0},
    '{64'h0, '1, 64'hffffffff00000000, 64'h00000000ffffffff, 1'b0, 64'h0, 64'h0},
    '{64'h0, '1, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0}
  };

  // ---- GF(2^8) helpers and S-box construction ----
  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_dbl(a);
    end
    return p;
  endfunction

  // multiplicative inverse followed by the affine map
  task automatic build_sub_table();
    logic [7:0] inv, b;
    for (int a = 0; a < 256; a++) begin
      inv = 8'h00;
      for (int c = 1; c < 256; c++) begin
        if (gf_mul(8'(a), 8'(c)) == 8'h01) inv = 8'(c);
      end
      b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sub_byte[a] = b;
    end
  endtask

  // ---- AES-128 forward cipher; byte 0 is the top byte of the high half ----
  function automatic cipher_t aes_encrypt(input logic [63:0] k_hi, input logic [63:0] k_lo,
                                          input logic [63:0] p_hi, input logic [63:0] p_lo);
    logic [7:0]   rk [11][16];
    logic [7:0]   st [16];
    logic [7:0]   tmp [16];
    logic [7:0]   tw [4];
    logic [7:0]   rc, f, a0, a1, a2, a3, al;
    logic [127:0] kk, pp, res;
    cipher_t      ct;
    kk = {k_hi, k_lo};
    pp = {p_hi, p_lo};
    for (int i = 0; i < 16; i++) begin
      rk[0][i] = kk[127 - 8*i -: 8];
      st[i]    = pp[127 - 8*i -: 8];
    end
    // key schedule, one word of four bytes at a time
    rc = 8'h01;
    for (int w = 4; w < 44; w++) begin
      for (int j = 0; j < 4; j++) tw[j] = rk[(w-1)/4][4*((w-1)%4) + j];
      if (w % 4 == 0) begin
        f     = tw[0];
        tw[0] = sub_byte[tw[1]] ^ rc;
        tw[1] = sub_byte[tw[2]];
        tw[2] = sub_byte[tw[3]];
        tw[3] = sub_byte[f];
        rc    = gf_dbl(rc);
      end
      for (int j = 0; j < 4; j++) rk[w/4][4*(w%4) + j] = rk[(w-4)/4][4*(w%4) + j] ^ tw[j];
    end
    for (int i = 0; i < 16; i++) st[i] ^= rk[0][i];
    for (int r = 1; r <= 10; r++) begin
      // SubBytes + ShiftRows: row r of column c comes from column c+r
      for (int c = 0; c < 4; c++)
        for (int q = 0; q < 4; q++) tmp[q + 4*c] = sub_byte[st[q + 4*((c + q) % 4)]];
      st = tmp;
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]   = a0 ^ al ^ gf_dbl(a0 ^ a1);
          st[4*c+1] = a1 ^ al ^ gf_dbl(a1 ^ a2);
          st[4*c+2] = a2 ^ al ^ gf_dbl(a2 ^ a3);
          st[4*c+3] = a3 ^ al ^ gf_dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] ^= rk[r][i];
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = st[i];
    ct.hi = res[127:64];
    ct.lo = res[63:0];
    return ct;
  endfunction

  // ---- clock and cycle limit ----
  initial begin
    int cyc;
    cyc = 0;
    clk = 1'b0;
    forever begin
      #5 clk = 1'b1;
      cyc++;
      if (cyc > CycleLimit) begin
        $display("tb_aes128_encrypt_block: done, errors");
        $finish;
      end
      #5 clk = 1'b0;
    end
  end

  // write one key half at a falling edge; only while the pipe is empty
  task automatic write_key(input cfg_idx_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_KEY_HIGH) key_hi_q = val;
    else key_lo_q = val;
  endtask

  // wait for every queued ciphertext, then let the pipe run dry
  task automatic drain_pipe();
    while (cipher_q.size() != 0) @(negedge clk);
    repeat (PipeDrain) @(negedge clk);
  endtask

  // offer one plaintext beat after a random gap unless calm is set; returns once accepted.
  // Called at a falling edge, leaves at a falling edge with tvalid low.
  task automatic send_block(input logic [63:0] p_hi, input logic [63:0] p_lo);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {p_lo, p_hi};
    do @(posedge clk); while (!in_tready);
    // beat accepted at this edge: predict under the key in force now
    cipher_q.insert(cipher_q.size(), aes_encrypt(key_hi_q, key_lo_q, p_hi, p_lo));
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic set_key(input logic [63:0] k_hi, input logic [63:0] k_lo);
    if (k_hi != key_hi_q || k_lo != key_lo_q) begin
      @(negedge clk) in_tvalid = 1'b0;
      drain_pipe();
      write_key(CFG_KEY_HIGH, k_hi);
      write_key(CFG_KEY_LOW, k_lo);
    end
  endtask

  // ---- result side: random stalls, one long hold, field checks ----
  initial begin
    int      stall;
    bit      held;
    cipher_t want;
    held   = 1'b0;
    rx_cnt = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && rx_cnt == HoldAt) begin
        held  = 1'b1;
        stall = HoldCycles;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 8);
      end
      if (stall != 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      rx_cnt++;
      if (cipher_q.size() == 0) begin
        $error("unexpected beat: cipher_high=%h cipher_low=%h",
               out_tdata[63:0], out_tdata[127:64]);
        err_cnt++;
      end else begin
        want = cipher_q.pop_front();
        if (out_tdata[63:0] !== want.hi) begin
          $error("cipher_high: expected %h, got %h", want.hi, out_tdata[63:0]);
          err_cnt++;
        end
        if (out_tdata[127:64] !== want.lo) begin
          $error("cipher_low: expected %h, got %h", want.lo, out_tdata[127:64]);
          err_cnt++;
        end
      end
    end
  end

  // ---- stimulus ----
  initial begin
    cipher_t model;
    logic [63:0] k_hi, k_lo;
    err_cnt   = 0;
    calm      = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_KEY_HIGH;
    cfg_wdata = '0;
    key_hi_q  = '0;
    key_lo_q  = '0;
    build_sub_table();
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed rows; known answers also vouch for the in-bench cipher
    for (int i = 0; i < NumRows; i++) begin
      set_key(rows[i].key_hi, rows[i].key_lo);
      if (rows[i].known) begin
        model = aes_encrypt(rows[i].key_hi, rows[i].key_lo, rows[i].pt_hi, rows[i].pt_lo);
        if (model.hi !== rows[i].ct_hi || model.lo !== rows[i].ct_lo) begin
          $error("cipher_high/low known answer: expected %h%h, model %h%h",
                 rows[i].ct_hi, rows[i].ct_lo, model.hi, model.lo);
          err_cnt++;
        end
      end
      send_block(rows[i].pt_hi, rows[i].pt_lo);
    end

    // random blocks in phases, each under its own key; extremes first
    for (int ph = 0; ph < KeyPhases; ph++) begin
      case (ph)
        0: begin k_hi = '1; k_lo = '1; end
        1: begin k_hi = '0; k_lo = '0; end
        default: begin
          k_hi = {$urandom, $urandom};
          k_lo = {$urandom, $urandom};
        end
      endcase
      set_key(k_hi, k_lo);
      for (int n = 0; n < RandItems / KeyPhases; n++) begin
        // occasionally switch between idling and back-to-back stretches
        if ($urandom_range(0, 99) == 0) calm = ~calm;
        case ($urandom_range(0, 9))
          0:       send_block('0, '1);
          1:       send_block('1, '0);
          default: send_block({$urandom, $urandom}, {$urandom, $urandom});
        endcase
      end
    end

    @(negedge clk) in_tvalid = 1'b0;
    drain_pipe();
    if (err_cnt == 0) begin
      $display("tb_aes128_encrypt_block: done, clean");
    end else begin
      $display("tb_aes128_encrypt_block: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/aes128_pkg.sv
rtl/core/aes128_round.sv
rtl/core/aes128_encrypt_block.sv
test/tb_aes128_encrypt_block.sv
